// ===== sv/eopu_pkg.sv =====
package eopu_pkg;

    localparam logic [17:0] CENTER_X_RESET = 18'd61440;
    localparam logic [17:0] CENTER_Y_RESET = 18'd34560;

    localparam logic [0:0] REG_CENTER_X = 1'b0;
    localparam logic [0:0] REG_CENTER_Y = 1'b1;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    localparam int RAD_W  = 36;
    localparam int ROOT_W = 18;

    localparam logic [16:0] RADIUS_MAX = 17'd131071;

    // one particle record, 124 bits
    typedef struct packed {
        logic [15:0]        axis_a;
        logic [15:0]        axis_b;
        logic [15:0]        tilt;
        logic signed [11:0] jx;
        logic signed [11:0] jy;
        logic [19:0]        speed;
        logic [31:0]        phase;
    } rec_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_status_t;

endpackage

// ===== sv/eopu_rec_mem.sv =====
module eopu_rec_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  eopu_pkg::rec_t  wdata,
    input  logic [AW-1:0]   raddr,
    output eopu_pkg::rec_t  rdata
);

    eopu_pkg::rec_t mem [DEPTH];
    eopu_pkg::rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/eopu_sqrt.sv =====
module eopu_sqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [eopu_pkg::RAD_W-1:0]        radicand,
    output logic [eopu_pkg::ROOT_W-1:0]       root,
    output eopu_pkg::sqrt_status_t            status
);

    logic [eopu_pkg::RAD_W-1:0]  rad_reg, rad_next;
    logic [eopu_pkg::ROOT_W+2:0] rem_reg, rem_next;
    logic [eopu_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [4:0]                  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [eopu_pkg::ROOT_W+2:0] rem_t;
    logic [eopu_pkg::ROOT_W+2:0] trial;

    // one root bit per cycle, two radicand bits brought down
    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_t     = {rem_reg[eopu_pkg::ROOT_W:0], rad_reg[eopu_pkg::RAD_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'(eopu_pkg::ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = rad_reg << 2;
            if (rem_t >= trial)
            begin
                rem_next  = rem_t - trial;
                root_next = {root_reg[eopu_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_t;
                root_next = {root_reg[eopu_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root        = root_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== sv/elliptical_orbit_particle_update_core.sv =====
// Particle orbit table. Records live in a single-port-write, registered-read
// memory of PARTICLE_COUNT entries of 124 bits.
// Input channel s_axis: tuser is the action (0 load, 1 advance), tdata the
// index, record fields and frame time. Output channel m_axis carries one item
// per input item: saturated position and the running maximum radius.
// Configuration channel cfg_*: index 0 writes center x, index 1 center y;
// always ready, write only while the block is idle.
// One item is worked at a time. A single shared 21x21 multiplier is stepped
// by the sequencer through phase advance, four sine/cosine evaluations of
// four multiplies each, and the ellipse and tilt products; then an
// iterative square root takes one result bit per cycle.
// A load goes straight to the memory write; an advance first does the memory
// read and the speed product. An index out of range goes straight to the
// output step. The next item is accepted once the result has moved to the
// output register.
// Reset clears the sequencer, the output valid, the running maximum and sets
// the center registers to their defaults; the record memory is not cleared,
// and a record must be loaded before it is advanced.
// When m_axis_tready is low the result holds in the output register and the
// block finishes the following item up to its output step, then waits.
module elliptical_orbit_particle_update_core #(
    parameter int PARTICLE_COUNT = 65536
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] particle_index, [31:16] semi_axis_x, [47:32] semi_axis_y,
    // [63:48] tilt_angle, [75:64] offset_x, [87:76] offset_y,
    // [107:88] angular_speed, [139:108] start_phase, [159:140] frame_time
    input  logic [159:0] s_axis_tdata,
    // [0] action
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [18:0] pos_x, [37:19] pos_y, [54:38] max_radius, [55] zero
    output logic [55:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [17:0]  cfg_data
);

    localparam int AW = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;

    typedef enum logic [19:0] {
        S_IDLE = 20'h00001,
        S_RD   = 20'h00002,
        S_ADV  = 20'h00004,
        S_WB   = 20'h00008,
        S_T1   = 20'h00010,
        S_T2   = 20'h00020,
        S_T3   = 20'h00040,
        S_T4   = 20'h00080,
        S_T5   = 20'h00100,
        S_L1   = 20'h00200,
        S_L2   = 20'h00400,
        S_L3   = 20'h00800,
        S_R1   = 20'h01000,
        S_R2   = 20'h02000,
        S_R3   = 20'h04000,
        S_R4   = 20'h08000,
        S_Q1   = 20'h10000,
        S_Q2   = 20'h20000,
        S_SQ   = 20'h40000,
        S_OUT  = 20'h80000
    } state_t;

    state_t state_reg, state_next;

    logic [17:0] cx_reg, cy_reg;
    logic [16:0] max_reg, max_next;
    logic        out_valid_reg;
    logic [55:0] out_data_reg;

    eopu_pkg::rec_t rec_reg, rec_next, mem_rdata, mem_wdata;
    logic [15:0]    idx_reg;
    logic           act_reg;
    logic           hit_reg;
    logic [19:0]    ft_reg;
    logic [1:0]     k_reg;
    logic [14:0]    x2_reg;
    logic signed [17:0] trig_reg [4];
    logic signed [18:0] lx_reg, ly_reg, rx_reg, ry_reg;
    logic signed [41:0] t_reg;
    logic signed [41:0] prod_reg;
    logic signed [20:0] mul_a, mul_b;
    logic               mem_we;
    logic [AW-1:0]      addr;

    logic [15:0] ang;
    logic [13:0] frac;
    logic [14:0] xq;
    logic [16:0] sq_mag;
    logic [15:0] u_val, v_val;
    logic [31:0] new_phase;

    logic [eopu_pkg::RAD_W-1:0]  sq_in;
    logic [eopu_pkg::ROOT_W-1:0] sq_root;
    eopu_pkg::sqrt_status_t      sq_stat;
    logic                        sq_start;

    logic signed [20:0] sum_x, sum_y;
    logic [18:0]        pos_x, pos_y;
    logic [16:0]        root_sat;

    function automatic logic signed [41:0] rnd14(input logic signed [41:0] p);
        logic signed [41:0] s;
        s = p + 42'sd8192;
        return s >>> 14;
    endfunction

    function automatic logic [18:0] sat19(input logic signed [20:0] v);
        logic [18:0] r;
        if (v > 21'sd262143)
            r = 19'h3FFFF;
        else if (v < -21'sd262144)
            r = 19'h40000;
        else
            r = v[18:0];
        return r;
    endfunction

    assign addr = AW'(idx_reg);

    eopu_rec_mem #(.DEPTH(PARTICLE_COUNT), .AW(AW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (addr),
        .wdata (mem_wdata),
        .raddr (addr),
        .rdata (mem_rdata)
    );

    eopu_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_in),
        .root     (sq_root),
        .status   (sq_stat)
    );

    // angle for the current sine/cosine evaluation
    always_comb
    begin
        case (k_reg)
            2'd0:    ang = rec_reg.phase[31:16] + 16'd16384;
            2'd1:    ang = rec_reg.phase[31:16];
            2'd2:    ang = rec_reg.tilt + 16'd16384;
            default: ang = rec_reg.tilt;
        endcase
        frac = ang[13:0];
        xq   = ang[14] ? (15'd16384 - {1'b0, frac}) : {1'b0, frac};
    end

    assign u_val     = 16'd21024 - 16'(prod_reg >>> 14);
    assign v_val     = 16'd51472 - 16'(prod_reg >>> 14);
    assign sq_mag    = prod_reg[31:15];
    assign new_phase = rec_reg.phase + prod_reg[39:8];

    assign sum_x = $signed({3'b000, cx_reg}) + (hit_reg ? 21'(rx_reg) : 21'sd0);
    assign sum_y = $signed({3'b000, cy_reg}) + (hit_reg ? 21'(ry_reg) : 21'sd0);
    assign pos_x = sat19(sum_x);
    assign pos_y = sat19(sum_y);
    assign root_sat = (sq_root > 18'(eopu_pkg::RADIUS_MAX)) ? eopu_pkg::RADIUS_MAX
                                                             : sq_root[16:0];
    assign sq_in = eopu_pkg::RAD_W'(t_reg + prod_reg);

    always_comb
    begin
        state_next = state_reg;
        rec_next   = rec_reg;
        max_next   = max_reg;
        mem_we     = 1'b0;
        mem_wdata  = rec_reg;
        mul_a      = '0;
        mul_b      = '0;
        sq_start   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (32'(s_axis_tdata[15:0]) >= 32'(PARTICLE_COUNT))
                        state_next = S_OUT;
                    else if (s_axis_tuser[0] == eopu_pkg::ACT_LOAD)
                        state_next = S_WB;
                    else
                        state_next = S_RD;
                    rec_next.axis_a = s_axis_tdata[31:16];
                    rec_next.axis_b = s_axis_tdata[47:32];
                    rec_next.tilt   = s_axis_tdata[63:48];
                    rec_next.jx     = s_axis_tdata[75:64];
                    rec_next.jy     = s_axis_tdata[87:76];
                    rec_next.speed  = s_axis_tdata[107:88];
                    rec_next.phase  = s_axis_tdata[139:108];
                end
            end
            S_RD:
                state_next = S_ADV;
            S_ADV:
            begin
                rec_next   = mem_rdata;
                mul_a      = 21'(mem_rdata.speed);
                mul_b      = 21'(ft_reg);
                state_next = S_WB;
            end
            S_WB:
            begin
                if (act_reg == eopu_pkg::ACT_ADVANCE)
                begin
                    rec_next.phase  = new_phase;
                    mem_wdata.phase = new_phase;
                end
                mem_we     = 1'b1;
                state_next = S_T1;
            end
            S_T1:
            begin
                mul_a      = 21'(xq);
                mul_b      = 21'(xq);
                state_next = S_T2;
            end
            S_T2:
            begin
                mul_a      = 21'(prod_reg[28:14]);
                mul_b      = 21'sd2320;
                state_next = S_T3;
            end
            S_T3:
            begin
                mul_a      = 21'(x2_reg);
                mul_b      = 21'(u_val);
                state_next = S_T4;
            end
            S_T4:
            begin
                mul_a      = 21'(xq);
                mul_b      = 21'(v_val);
                state_next = S_T5;
            end
            S_T5:
                state_next = (k_reg == 2'd3) ? S_L1 : S_T1;
            S_L1:
            begin
                mul_a      = 21'(rec_reg.axis_a);
                mul_b      = 21'(trig_reg[0]);
                state_next = S_L2;
            end
            S_L2:
            begin
                mul_a      = 21'(rec_reg.axis_b);
                mul_b      = 21'(trig_reg[1]);
                state_next = S_L3;
            end
            S_L3:
            begin
                mul_a      = 21'(lx_reg);
                mul_b      = 21'(trig_reg[2]);
                state_next = S_R1;
            end
            S_R1:
            begin
                mul_a      = 21'(ly_reg);
                mul_b      = 21'(trig_reg[3]);
                state_next = S_R2;
            end
            S_R2:
            begin
                mul_a      = 21'(lx_reg);
                mul_b      = 21'(trig_reg[3]);
                state_next = S_R3;
            end
            S_R3:
            begin
                mul_a      = 21'(ly_reg);
                mul_b      = 21'(trig_reg[2]);
                state_next = S_R4;
            end
            S_R4:
            begin
                mul_a      = 21'(rx_reg);
                mul_b      = 21'(rx_reg);
                state_next = S_Q1;
            end
            S_Q1:
            begin
                mul_a      = 21'(ry_reg);
                mul_b      = 21'(ry_reg);
                state_next = S_Q2;
            end
            S_Q2:
            begin
                sq_start   = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                if (sq_stat.done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    if (hit_reg && root_sat > max_reg)
                        max_next = root_sat;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cx_reg        <= eopu_pkg::CENTER_X_RESET;
            cy_reg        <= eopu_pkg::CENTER_Y_RESET;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            max_reg   <= max_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    eopu_pkg::REG_CENTER_X: cx_reg <= cfg_data;
                    eopu_pkg::REG_CENTER_Y: cy_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == S_OUT && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_WB)
                k_reg <= '0;
            else if (state_reg == S_T5)
                k_reg <= k_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg  <= rec_next;
        prod_reg <= mul_a * mul_b;
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            idx_reg <= s_axis_tdata[15:0];
            act_reg <= s_axis_tuser[0];
            ft_reg  <= s_axis_tdata[159:140];
            hit_reg <= (32'(s_axis_tdata[15:0]) < 32'(PARTICLE_COUNT));
        end
        if (state_reg == S_T2)
            x2_reg <= prod_reg[28:14];
        if (state_reg == S_T5)
            trig_reg[k_reg] <= ang[15] ? -$signed({1'b0, sq_mag})
                                       : $signed({1'b0, sq_mag});
        if (state_reg == S_L2)
            lx_reg <= 19'(rnd14(prod_reg)) + 19'(rec_reg.jx);
        if (state_reg == S_L3)
            ly_reg <= 19'(rnd14(-prod_reg)) + 19'(rec_reg.jy);
        if (state_reg == S_R1 || state_reg == S_R3 || state_reg == S_Q1)
            t_reg <= prod_reg;
        if (state_reg == S_R2)
            rx_reg <= 19'(rnd14(t_reg - prod_reg));
        if (state_reg == S_R4)
            ry_reg <= 19'(rnd14(t_reg + prod_reg));
        if (state_reg == S_OUT && (!out_valid_reg || m_axis_tready))
            out_data_reg <= {1'b0, max_next, pos_y, pos_x};
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

`ifndef ASSERT_OFF
    a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        max_reg >= $past(max_reg))
        else $error("running maximum decreased");

    a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sq_stat.done |-> state_reg == S_SQ)
        else $error("root finished outside its wait step");

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("stalled result dropped");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg != S_IDLE)
        else $error("accepted item not started");
`endif

endmodule
